[rtl/hcf_pkg.sv]
// Package for the helix causal filter: payload words, tap settings and codes.
// Used by hcf_front, hcf_back and helix_causal_filter_unit; depends on nothing.
package hcf_pkg;

  localparam int NUM_TAPS   = 6;
  localparam int TAP_IDX_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int ACC_W      = 34;
  localparam int PROD_W     = 50;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TAP_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_F    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_MODE = 3'd7;

  localparam logic signed [15:0] GAIN_RESET = 16'sd256;

  // Input word.
  typedef struct packed {
    logic signed [15:0] model_sample;
    logic signed [23:0] prior_sample;
    logic               vector_end;
  } in_t;

  // Result word.
  typedef struct packed {
    logic signed [23:0] data_sample;
    logic               last_out;
  } out_t;

  // One tap register: coefficient in the upper bits, lag in the lower bits.
  typedef struct packed {
    logic signed [15:0] coef;
    logic [23:0]        lag;
  } tap_cfg_t;

  // Classified word handed from the front to the back.
  typedef struct packed {
    in_t                 item;
    logic [NUM_TAPS-1:0] tap_en;
    logic [NUM_TAPS-1:0] tap_zero;
  } task_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_SCALE,
    ST_ROUND
  } back_state_t;

endpackage

[rtl/hcf_front.sv]
// Front end of the helix causal filter: accepts input words, tracks the ring
// write pointer and vector position, and queues classified words. Uses hcf_pkg.
module hcf_front #(
  parameter int MAX_LAG   = 1024,
  parameter int TAP_COUNT = 6,
  parameter int AW        = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  hcf_pkg::in_t                          item,
  input  hcf_pkg::tap_cfg_t [hcf_pkg::NUM_TAPS-1:0] taps,
  output logic                                  task_valid,
  output hcf_pkg::task_t                        task_data,
  output logic [AW-1:0]                         task_wp,
  input  logic                                  task_pop
);

  logic [AW-1:0]         wp;
  logic [23:0]           seen;
  hcf_pkg::task_t        q_data [2];
  logic [AW-1:0]         q_wp   [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  accept;
  hcf_pkg::task_t        new_task;

  assign accept = push && !full;
  assign full   = (count == 2'd2);

  // Decide per tap whether it contributes, and whether it uses the current word.
  always_comb begin
    new_task.item = item;
    for (int t = 0; t < hcf_pkg::NUM_TAPS; t++) begin
      new_task.tap_en[t] = (t < TAP_COUNT) && (taps[t].coef != 16'sd0) &&
                           ({1'b0, taps[t].lag} <= 25'(MAX_LAG)) &&
                           (taps[t].lag <= seen);
      new_task.tap_zero[t] = (taps[t].lag == 24'd0);
    end
  end

  // Ring pointer and position within the vector.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      seen <= '0;
    end else if (accept) begin
      wp <= (wp == AW'(MAX_LAG - 1)) ? '0 : wp + 1'b1;
      if (item.vector_end) begin
        seen <= '0;
      end else if (seen != 24'hFFFFFF) begin
        seen <= seen + 24'd1;
      end
    end
  end

  // Two-entry queue towards the back end.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_data[wr_ptr] <= new_task;
      q_wp[wr_ptr]   <= wp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (task_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({accept, task_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign task_valid = (count != 2'd0);
  assign task_data  = q_data[rd_ptr];
  assign task_wp    = q_wp[rd_ptr];

endmodule

[rtl/hcf_back.sv]
// Back end of the helix causal filter: history ring memory, tap
// multiply-accumulate sequencer, gain, rounding and result queue. Uses hcf_pkg.
module hcf_back #(
  parameter int MAX_LAG = 1024,
  parameter int AW      = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hcf_pkg::tap_cfg_t [hcf_pkg::NUM_TAPS-1:0] taps,
  input  logic signed [15:0]                    gain,
  input  logic                                  add_mode,
  input  logic                                  task_valid,
  input  hcf_pkg::task_t                        task_data,
  input  logic [AW-1:0]                         task_wp,
  output logic                                  task_pop,
  output logic                                  empty,
  input  logic                                  pop,
  output hcf_pkg::out_t                         result
);

  localparam int LW = AW + 1;

  hcf_pkg::back_state_t           st, st_next;
  logic [hcf_pkg::TAP_IDX_W-1:0]  tap_idx;
  hcf_pkg::task_t                 cur;
  logic [AW-1:0]                  cur_wp;
  logic signed [hcf_pkg::ACC_W-1:0]  acc;
  logic signed [hcf_pkg::PROD_W-1:0] prod;
  logic signed [15:0]             ring [MAX_LAG];
  logic signed [15:0]             rd_data;
  logic [AW-1:0]                  rd_addr;
  logic [LW-1:0]                  lag_cut;
  logic [LW-1:0]                  diff;
  logic signed [15:0]             past;
  logic signed [31:0]             tap_prod;
  logic signed [hcf_pkg::PROD_W-1:0] rsum;
  logic signed [27:0]             rnd;
  logic signed [28:0]             total;
  logic signed [23:0]             sat;
  logic                           last_tap;
  logic                           res_push;
  logic                           res_full;
  hcf_pkg::out_t                  o_data [2];
  logic                           o_wr;
  logic                           o_rd;
  logic [1:0]                     o_cnt;

  // Ring address of the current tap, wrapped at the ring depth.
  assign lag_cut = taps[tap_idx].lag[LW-1:0];
  assign diff    = {1'b0, cur_wp} - lag_cut;
  assign rd_addr = ({1'b0, cur_wp} >= lag_cut) ? diff[AW-1:0]
                                               : AW'(diff + LW'(MAX_LAG));

  // History ring: written once per word, read at the current tap's address.
  always_ff @(posedge clk) begin
    if (st == hcf_pkg::ST_ROUND && !res_full) begin
      ring[cur_wp] <= cur.item.model_sample;
    end
    rd_data <= ring[rd_addr];
  end

  // Tap product and final rounding with saturation.
  always_comb begin
    past     = cur.tap_zero[tap_idx] ? cur.item.model_sample : rd_data;
    tap_prod = taps[tap_idx].coef * past;
    rsum     = prod + 50'sd2097152;
    rnd      = rsum[hcf_pkg::PROD_W-1:22];
    total    = 29'(rnd) + (add_mode ? 29'(cur.item.prior_sample) : 29'sd0);
    if (total > 29'sd8388607) begin
      sat = 24'sh7FFFFF;
    end else if (total < -29'sd8388608) begin
      sat = -24'sd8388608;
    end else begin
      sat = total[23:0];
    end
  end

  assign last_tap = (tap_idx == hcf_pkg::TAP_IDX_W'(hcf_pkg::NUM_TAPS - 1));
  assign res_full = (o_cnt == 2'd2);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= hcf_pkg::ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    st_next  = st;
    task_pop = 1'b0;
    res_push = 1'b0;
    unique case (st)
      hcf_pkg::ST_IDLE: begin
        if (task_valid) begin
          task_pop = 1'b1;
          st_next  = hcf_pkg::ST_READ;
        end
      end
      hcf_pkg::ST_READ: begin
        if (cur.tap_en[tap_idx]) begin
          st_next = hcf_pkg::ST_MAC;
        end else if (last_tap) begin
          st_next = hcf_pkg::ST_SCALE;
        end
      end
      hcf_pkg::ST_MAC: begin
        st_next = last_tap ? hcf_pkg::ST_SCALE : hcf_pkg::ST_READ;
      end
      hcf_pkg::ST_SCALE: begin
        st_next = hcf_pkg::ST_ROUND;
      end
      hcf_pkg::ST_ROUND: begin
        if (!res_full) begin
          res_push = 1'b1;
          st_next  = hcf_pkg::ST_IDLE;
        end
      end
      default: st_next = hcf_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (st)
      hcf_pkg::ST_IDLE: begin
        cur     <= task_data;
        cur_wp  <= task_wp;
        acc     <= hcf_pkg::ACC_W'(task_data.item.model_sample) <<< 14;
        tap_idx <= '0;
      end
      hcf_pkg::ST_READ: begin
        if (!cur.tap_en[tap_idx] && !last_tap) begin
          tap_idx <= tap_idx + 1'b1;
        end
      end
      hcf_pkg::ST_MAC: begin
        acc <= acc + hcf_pkg::ACC_W'(tap_prod);
        if (!last_tap) begin
          tap_idx <= tap_idx + 1'b1;
        end
      end
      hcf_pkg::ST_SCALE: begin
        prod <= acc * gain;
      end
      default: begin
      end
    endcase
  end

  // Two-entry result queue.
  always_ff @(posedge clk) begin
    if (res_push) begin
      o_data[o_wr].data_sample <= sat;
      o_data[o_wr].last_out    <= cur.item.vector_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr  <= 1'b0;
      o_rd  <= 1'b0;
      o_cnt <= 2'd0;
    end else begin
      if (res_push) begin
        o_wr <= ~o_wr;
      end
      if (pop && !empty) begin
        o_rd <= ~o_rd;
      end
      case ({res_push, pop && !empty})
        2'b10:   o_cnt <= o_cnt + 2'd1;
        2'b01:   o_cnt <= o_cnt - 2'd1;
        default: o_cnt <= o_cnt;
      endcase
    end
  end

  assign empty  = (o_cnt == 2'd0);
  assign result = o_data[o_rd];

endmodule

[rtl/helix_causal_filter_unit.sv]
// Top level of the helix causal filter: configuration registers, front end
// and back end. Uses hcf_pkg, hcf_front and hcf_back.
//
// Each input word yields one result word: gain times the sum of the current
// model sample and each enabled tap's coefficient times the sample lag places
// earlier in the same vector, rounded half up once, plus the prior sample in
// add mode, saturated to 24 bits. The back end visits the taps in turn
// through the single read port of the history ring, with a read step per
// tap and a multiply-accumulate step per enabled tap, one word at a time. Two
// words can wait ahead of the back end and two results behind it. The ring
// needs no clearing after reset; configuration writes are always taken.
module helix_causal_filter_unit #(
  parameter int MAX_LAG   = 1024,
  parameter int TAP_COUNT = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  hcf_pkg::in_t                     item,
  output logic                             empty,
  input  logic                             pop,
  output hcf_pkg::out_t                    result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hcf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hcf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_LAG);

  hcf_pkg::tap_cfg_t [hcf_pkg::NUM_TAPS-1:0] taps;
  logic signed [15:0]  gain;
  logic                add_mode;
  logic                task_valid;
  logic                task_pop;
  hcf_pkg::task_t      task_data;
  logic [AW-1:0]       task_wp;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      taps     <= '0;
      gain     <= hcf_pkg::GAIN_RESET;
      add_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        [hcf_pkg::REG_TAP_A:hcf_pkg::REG_TAP_F]:
          taps[cfg_index] <= cfg_data;
        hcf_pkg::REG_GAIN:     gain     <= cfg_data[15:0];
        hcf_pkg::REG_ADD_MODE: add_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  hcf_front #(
    .MAX_LAG   (MAX_LAG),
    .TAP_COUNT (TAP_COUNT),
    .AW        (AW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .taps       (taps),
    .task_valid (task_valid),
    .task_data  (task_data),
    .task_wp    (task_wp),
    .task_pop   (task_pop)
  );

  hcf_back #(
    .MAX_LAG (MAX_LAG),
    .AW      (AW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .taps       (taps),
    .gain       (gain),
    .add_mode   (add_mode),
    .task_valid (task_valid),
    .task_data  (task_data),
    .task_wp    (task_wp),
    .task_pop   (task_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

`ifndef SYNTHESIS
  // The back end only takes a word the front end has queued.
  a_pop_has_word: assert property (@(posedge clk) disable iff (rst)
    task_pop |-> task_valid) else $error("back end took a word from an empty queue");

  // An accepted input word is waiting for the back end on the next cycle.
  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> task_valid) else $error("accepted word missing from queue");
`endif

endmodule
